[rtl/core/sbrb_pkg.sv]
// Shared constants, codes, types and helpers of the stereo block ring buffer.
package sbrb_pkg;

	// Geometry of the ring
	localparam int BLOCK_PAIRS = 16;
	localparam int MAX_BLOCKS  = 16;
	localparam int SAMPLE_BITS = 32;

	localparam int STORE_DEPTH = MAX_BLOCKS * BLOCK_PAIRS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int BLK_W       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int PAIR_W      = (BLOCK_PAIRS > 1) ? $clog2(BLOCK_PAIRS) : 1;
	localparam int WORD_W      = 2 * SAMPLE_BITS;

	// Port field widths
	localparam int REQ_W  = 3;
	localparam int SMP_W  = 32;
	localparam int OFF_W  = 4;
	localparam int STAT_W = 2;
	localparam int CAP_W  = 5;
	localparam int CNT_W  = CAP_W;
	localparam int SUM_W  = CAP_W + 1;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH    = 3'd0,
		REQ_POP     = 3'd1,
		REQ_PEEK    = 3'd2,
		REQ_BACK    = 3'd3,
		REQ_DISCARD = 3'd4,
		REQ_BUMP    = 3'd5
	} req_code_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DATA   = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_OFFSET = 2'd2
	} stat_code_t;

	// Memory access issued by the controller
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Tag that travels alongside the memory read latency
	typedef struct packed {
		logic              valid;
		logic              is_status;
		logic [STAT_W-1:0] status;
		logic              last;
	} rd_tag_t;

	// One result item
	typedef struct packed {
		logic [SMP_W-1:0]  left;
		logic [SMP_W-1:0]  right;
		logic              last;
		logic [STAT_W-1:0] status;
	} out_item_t;

	// Word address of a pair within the store
	function automatic logic [ADDR_W-1:0] pair_addr(input logic [BLK_W-1:0] blk,
		input logic [PAIR_W-1:0] pos);
		return ADDR_W'(ADDR_W'(blk) * ADDR_W'(BLOCK_PAIRS) + ADDR_W'(pos));
	endfunction

	// Clamp a written capacity to the usable range
	function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] v);
		if (v == '0) begin
			return CAP_W'(1);
		end else if (v > CAP_W'(MAX_BLOCKS)) begin
			return CAP_W'(MAX_BLOCKS);
		end
		return v;
	endfunction

endpackage

[rtl/core/sbrb_if.sv]
// Channel interfaces of the stereo block ring buffer: request, result and capacity write.
interface sbrb_req_if;
	logic                      valid;
	logic                      ready;
	logic [sbrb_pkg::REQ_W-1:0] req_type;
	logic signed [sbrb_pkg::SMP_W-1:0] left_sample;
	logic signed [sbrb_pkg::SMP_W-1:0] right_sample;
	logic [sbrb_pkg::OFF_W-1:0] block_offset;

	modport source (output valid, req_type, left_sample, right_sample, block_offset,
		input ready);
	modport sink (input valid, req_type, left_sample, right_sample, block_offset,
		output ready);
endinterface

interface sbrb_rsp_if;
	logic                       valid;
	logic                       ready;
	logic signed [sbrb_pkg::SMP_W-1:0] out_left;
	logic signed [sbrb_pkg::SMP_W-1:0] out_right;
	logic                       out_last;
	logic [sbrb_pkg::STAT_W-1:0] status;

	modport source (output valid, out_left, out_right, out_last, status, input ready);
	modport sink (input valid, out_left, out_right, out_last, status, output ready);
endinterface

interface sbrb_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [sbrb_pkg::CAP_W-1:0] capacity;

	modport source (output valid, capacity, input ready);
	modport sink (input valid, capacity, output ready);
endinterface

[rtl/core/sbrb_store.sv]
// Sample store: one write port, one read port, registered read data.
module sbrb_store (
	input  logic                        clk,
	input  sbrb_pkg::mem_req_t          mem_req,
	output logic [sbrb_pkg::WORD_W-1:0] rdata
);
	import sbrb_pkg::*;

	logic [WORD_W-1:0] mem [STORE_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// Write one pair
	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
	end

	// Read one pair, hold the data otherwise
	always_ff @(posedge clk) begin
		if (mem_req.re) begin
			rdata_q <= mem[mem_req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/sbrb_outq.sv]
// Two-entry result queue that turns read data and status tags into result transfers.
module sbrb_outq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sbrb_pkg::rd_tag_t           tag_s1,
	input  logic [sbrb_pkg::WORD_W-1:0] rdata,
	output logic                        can_issue,
	sbrb_rsp_if.source                  rsp
);
	import sbrb_pkg::*;

	out_item_t entry_q [2];
	logic [1:0] count_q;
	logic       head_q;
	logic       tail;
	logic       push;
	logic       pop;
	logic [2:0] occ_next;
	out_item_t  item;

	assign push = tag_s1.valid;
	assign pop  = rsp.valid && rsp.ready;
	assign tail = head_q ^ count_q[0];

	// Allow an issue only when its result will find a free entry
	assign occ_next  = 3'(count_q) - 3'(pop) + 3'(push);
	assign can_issue = occ_next < 3'd2;

	// Build the item: status results carry zero samples
	always_comb begin
		item.last   = tag_s1.last;
		item.status = tag_s1.status;
		if (tag_s1.is_status) begin
			item.left  = '0;
			item.right = '0;
		end else begin
			item.left  = SMP_W'($signed(rdata[SAMPLE_BITS-1:0]));
			item.right = SMP_W'($signed(rdata[WORD_W-1:SAMPLE_BITS]));
		end
	end

	// Hold queued results
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail] <= item;
		end
	end

	// Advance head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= 1'b0;
		end else begin
			count_q <= 2'(occ_next);
			if (pop) begin
				head_q <= ~head_q;
			end
		end
	end

	assign rsp.valid     = count_q != 2'd0;
	assign rsp.out_left  = entry_q[head_q].left;
	assign rsp.out_right = entry_q[head_q].right;
	assign rsp.out_last  = entry_q[head_q].last;
	assign rsp.status    = entry_q[head_q].status;

endmodule

[rtl/core/sbrb_ctrl.sv]
// Controller: ring pointers, capacity register, request decode and block read sequencer.
module sbrb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               can_issue,
	output sbrb_pkg::mem_req_t mem_req,
	output sbrb_pkg::rd_tag_t  tag_s1,
	sbrb_req_if.sink           req,
	sbrb_cfg_if.sink           cfg
);
	import sbrb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_READ
	} state_t;

	state_t             state_q;
	logic [CAP_W-1:0]   cap_q;
	logic [BLK_W-1:0]   wb_q;
	logic [BLK_W-1:0]   rb_q;
	logic [BLK_W-1:0]   wb_mod_q;
	logic [BLK_W-1:0]   rb_mod_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PAIR_W-1:0]  fill_q;
	logic [BLK_W-1:0]   rdblk_q;
	logic [PAIR_W-1:0]  pair_q;
	rd_tag_t            tag_q;
	rd_tag_t            tag_d;

	logic               accept;
	logic               cfg_xfer;
	logic [SUM_W-1:0]   cap_w;
	logic [SUM_W-1:0]   wb_w;
	logic [SUM_W-1:0]   rb_w;
	logic [SUM_W-1:0]   off_w;
	logic               off_bad;
	logic [SUM_W-1:0]   peek_sum;
	logic [SUM_W-1:0]   back_sum;
	logic [BLK_W-1:0]   peek_blk;
	logic [BLK_W-1:0]   back_blk;
	logic [BLK_W-1:0]   wb_adv;
	logic [BLK_W-1:0]   rb_adv;
	logic [CNT_W-1:0]   cnt_sat;
	logic               wb_big;
	logic               rb_big;
	logic               last_pair;

	// Handshakes: configuration wins over a request in the same cycle
	assign cfg.ready = state_q == ST_IDLE;
	assign cfg_xfer  = cfg.valid && cfg.ready;
	assign req.ready = (state_q == ST_IDLE) && can_issue && !cfg.valid;
	assign accept    = req.valid && req.ready;

	// Pointer arithmetic on the working copies, which are kept below the capacity.
	// The stored pointers keep their written values until they advance.
	assign cap_w    = SUM_W'(cap_q);
	assign wb_w     = SUM_W'(wb_mod_q);
	assign rb_w     = SUM_W'(rb_mod_q);
	assign off_w    = SUM_W'(req.block_offset);
	assign off_bad  = off_w >= cap_w;
	assign peek_sum = rb_w + off_w;
	assign back_sum = wb_w + cap_w - SUM_W'(1) - off_w;
	assign peek_blk = BLK_W'((peek_sum >= cap_w) ? peek_sum - cap_w : peek_sum);
	assign back_blk = BLK_W'((back_sum >= cap_w) ? back_sum - cap_w : back_sum);
	assign wb_adv   = (wb_w + SUM_W'(1) == cap_w) ? '0 : BLK_W'(wb_w + SUM_W'(1));
	assign rb_adv   = (rb_w + SUM_W'(1) == cap_w) ? '0 : BLK_W'(rb_w + SUM_W'(1));
	assign cnt_sat  = (cnt_q < cap_q) ? cnt_q + CNT_W'(1) : cap_q;
	assign wb_big   = wb_w >= cap_w;
	assign rb_big   = rb_w >= cap_w;
	assign last_pair = pair_q == PAIR_W'(BLOCK_PAIRS - 1);

	// Memory accesses: push writes on accept, reads stream in the read state.
	// Writes and reads never share a cycle, so no forwarding is needed.
	always_comb begin
		mem_req.we    = accept && (req.req_type == REQ_PUSH);
		mem_req.waddr = pair_addr(wb_mod_q, fill_q);
		mem_req.wdata = {req.right_sample[SAMPLE_BITS-1:0],
			req.left_sample[SAMPLE_BITS-1:0]};
		mem_req.re    = (state_q == ST_READ) && can_issue;
		mem_req.raddr = pair_addr(rdblk_q, pair_q);
	end

	// Next read tag: status results on accept, data tags while streaming
	always_comb begin
		tag_d = '0;
		if (accept) begin
			if ((req.req_type == REQ_POP) && (cnt_q == '0)) begin
				tag_d = '{valid: 1'b1, is_status: 1'b1, status: STAT_EMPTY, last: 1'b1};
			end else if (((req.req_type == REQ_PEEK) || (req.req_type == REQ_BACK)) &&
				off_bad) begin
				tag_d = '{valid: 1'b1, is_status: 1'b1, status: STAT_OFFSET, last: 1'b1};
			end
		end else if ((state_q == ST_READ) && can_issue) begin
			tag_d = '{valid: 1'b1, is_status: 1'b0, status: STAT_DATA, last: last_pair};
		end
	end

	assign tag_s1 = tag_q;

	// State, pointers and the read tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cap_q    <= CAP_W'(MAX_BLOCKS);
			wb_q     <= '0;
			rb_q     <= '0;
			wb_mod_q <= '0;
			rb_mod_q <= '0;
			cnt_q    <= '0;
			fill_q   <= '0;
			rdblk_q  <= '0;
			pair_q   <= '0;
			tag_q    <= '0;
		end else begin
			tag_q <= tag_d;
			case (state_q)
				ST_IDLE: begin
					if (cfg_xfer) begin
						cap_q    <= eff_cap(cfg.capacity);
						wb_mod_q <= wb_q;
						rb_mod_q <= rb_q;
						state_q  <= ST_NORM;
					end else if (accept) begin
						case (req.req_type)
							REQ_PUSH: begin
								if (fill_q == PAIR_W'(BLOCK_PAIRS - 1)) begin
									wb_q     <= wb_adv;
									wb_mod_q <= wb_adv;
									cnt_q    <= cnt_sat;
									fill_q   <= '0;
								end else begin
									fill_q <= fill_q + PAIR_W'(1);
								end
							end
							REQ_POP: begin
								if (cnt_q != '0) begin
									rdblk_q  <= rb_mod_q;
									rb_q     <= rb_adv;
									rb_mod_q <= rb_adv;
									cnt_q    <= cnt_q - CNT_W'(1);
									pair_q   <= '0;
									state_q  <= ST_READ;
								end
							end
							REQ_PEEK, REQ_BACK: begin
								if (!off_bad) begin
									rdblk_q <= (req.req_type == REQ_PEEK) ? peek_blk : back_blk;
									pair_q  <= '0;
									state_q <= ST_READ;
								end
							end
							REQ_DISCARD: begin
								if (cnt_q != '0) begin
									rb_q     <= rb_adv;
									rb_mod_q <= rb_adv;
									cnt_q    <= cnt_q - CNT_W'(1);
								end
							end
							REQ_BUMP: begin
								wb_q     <= wb_adv;
								wb_mod_q <= wb_adv;
								cnt_q    <= cnt_sat;
								fill_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_NORM: begin
					// Reduce the working pointers modulo the new capacity
					if (wb_big) begin
						wb_mod_q <= BLK_W'(wb_w - cap_w);
					end
					if (rb_big) begin
						rb_mod_q <= BLK_W'(rb_w - cap_w);
					end
					if (!wb_big && !rb_big) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					// Issue one pair read per cycle while the result queue has room
					if (can_issue) begin
						if (last_pair) begin
							state_q <= ST_IDLE;
						end else begin
							pair_q <= pair_q + PAIR_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/stereo_block_ring_buffer_core.sv]
// Top level of the stereo block ring buffer: controller, sample store and result queue.
//
// A ring of up to 16 blocks of 16 stereo pairs held in one 256 x 64 synchronous RAM.
// A push, discard, bump or ignored request completes on acceptance. Pop, peek and
// peek back stream a block of 16 results, one pair per cycle off the single RAM read
// port while the result queue has room; an empty pop or a bad offset gives one status
// result and no block read. No new request is taken while a block is streaming. A
// capacity write keeps the stored pointers and reduces working copies of them modulo
// the new capacity by repeated subtraction, which holds off requests until both copies
// are below it. Results pass through a two-entry queue, so a stalled result side stalls
// requests only once the queue fills.
module stereo_block_ring_buffer_core (
	input  logic       clk,
	input  logic       arst_n,
	sbrb_cfg_if.sink   cfg,
	sbrb_req_if.sink   req,
	sbrb_rsp_if.source rsp
);
	import sbrb_pkg::*;

	mem_req_t          mem_req;
	rd_tag_t           tag_s1;
	logic [WORD_W-1:0] rdata;
	logic              can_issue;

	// Decode requests and sequence block reads
	sbrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.can_issue (can_issue),
		.mem_req   (mem_req),
		.tag_s1    (tag_s1),
		.req       (req),
		.cfg       (cfg)
	);

	// Hold the samples
	sbrb_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	// Queue results for transfer
	sbrb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.rdata     (rdata),
		.can_issue (can_issue),
		.rsp       (rsp)
	);

endmodule
